@@ src/chpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpt_pkg
// Shared widths, hash multipliers, result codes and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package chpt_pkg;

    localparam int KEY_W          = 32;
    localparam int SLOT_OUT_W     = 11;
    localparam int STATUS_W       = 2;

    localparam int DEF_TABLE_SIZE = 1024;
    localparam int DEF_KICK_LIMIT = 16;

    localparam logic [KEY_W-1:0] MUL_ONE   = 32'd2654435761;
    localparam logic [KEY_W-1:0] MUL_TWO   = 32'd3344921057;
    localparam logic [KEY_W-1:0] EMPTY_KEY = '0;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FIND   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FAILED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_SEL_A    = 2'd0,
        RD_SEL_B    = 2'd1,
        RD_SEL_SIDE = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SEL_CLR = 2'd0,
        WR_SEL_A   = 2'd1,
        WR_SEL_B   = 2'd2,
        WR_SEL_CUR = 2'd3
    } wr_sel_t;

    typedef enum logic [1:0] {
        RS_NONE = 2'd0,
        RS_A    = 2'd1,
        RS_B    = 2'd2
    } res_slot_t;

    typedef struct packed {
        logic      accept;
        logic      kick;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      cap_resid;
        logic      cur_from_a;
        logic      wr_en;
        wr_sel_t   wr_sel;
        logic      res_load;
        status_t   res_status;
        res_slot_t res_slot;
        logic      out_load;
    } chpt_cmd_t;

    typedef struct packed {
        logic hash_done;
        logic key_zero;
        logic mode_find;
        logic rd_zero;
        logic rd_hit;
        logic resid_zero;
        logic evict_last;
        logic clear_last;
        logic out_free;
    } chpt_sts_t;

endpackage

@@ src/chpt_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpt_req_if
// Request channel: one word carries an operation mode and a key.
// ----------------------------------------------------------------------------
interface chpt_req_if import chpt_pkg::*;;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);

endinterface

@@ src/chpt_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpt_rsp_if
// Response channel: one word carries a status code and a slot index.
// ----------------------------------------------------------------------------
interface chpt_rsp_if import chpt_pkg::*;;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);

endinterface

@@ src/chpt_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpt_hash
// Four-stage home slot unit: multiplicative hash in both lanes, then the
// remainder by the table size through a reciprocal product and one correction.
// ----------------------------------------------------------------------------
module chpt_hash import chpt_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [KEY_W-1:0]                  key,
    output logic                              done,
    output logic [$clog2(2*TABLE_SIZE)-1:0]   slot_a,
    output logic [$clog2(2*TABLE_SIZE)-1:0]   slot_b
);

    localparam int               AW         = $clog2(2*TABLE_SIZE);
    localparam logic [32:0]      RECIP_WIDE = 33'h1_0000_0000 / 33'(TABLE_SIZE);
    localparam logic [31:0]      RECIP      = RECIP_WIDE[31:0];
    localparam logic [31:0]      SIZE32     = 32'(TABLE_SIZE);
    localparam logic [AW-1:0]    SIZE_AW    = AW'(TABLE_SIZE);
    localparam logic [KEY_W-1:0] LANE_MUL [2] = '{MUL_ONE, MUL_TWO};

    logic [3:0]       v_reg;
    logic [31:0]      p_reg  [2];
    logic [31:0]      pd_reg [2];
    logic [31:0]      q_reg  [2];
    logic [AW-1:0]    r_reg  [2];
    logic [AW-1:0]    h_reg  [2];

    logic [31:0]      p_next [2];
    logic [63:0]      qp     [2];
    logic [31:0]      qt     [2];
    logic [31:0]      diff   [2];
    logic [AW-1:0]    h_next [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            p_next[i] = key * LANE_MUL[i];
            qp[i]     = {32'b0, p_reg[i]} * {32'b0, RECIP};
            qt[i]     = q_reg[i] * SIZE32;
            diff[i]   = pd_reg[i] - qt[i];
            // the estimate is at most one short, so one subtract corrects it;
            // lane two adds the half offset instead of subtracting
            if (i == 0)
            begin
                h_next[i] = (r_reg[i] >= SIZE_AW) ? r_reg[i] - SIZE_AW : r_reg[i];
            end
            else
            begin
                h_next[i] = (r_reg[i] >= SIZE_AW) ? r_reg[i] : r_reg[i] + SIZE_AW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (start)
            begin
                p_reg[i] <= p_next[i];
            end
            if (v_reg[0])
            begin
                pd_reg[i] <= p_reg[i];
                q_reg[i]  <= qp[i][63:32];
            end
            if (v_reg[1])
            begin
                r_reg[i] <= diff[i][AW-1:0];
            end
            if (v_reg[2])
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    assign done   = v_reg[3];
    assign slot_a = h_reg[0];
    assign slot_b = h_reg[1];

endmodule

@@ src/chpt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpt_datapath
// Key store, hash unit, working key and eviction registers, result and
// output word registers.
// ----------------------------------------------------------------------------
module chpt_datapath import chpt_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KICK_LIMIT = DEF_KICK_LIMIT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  chpt_cmd_t             cmd,
    output chpt_sts_t             sts,
    input  logic                  req_mode,
    input  logic [KEY_W-1:0]      req_key,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output logic [STATUS_W-1:0]   rsp_status,
    output logic [SLOT_OUT_W-1:0] rsp_slot
);

    localparam int            DEPTH     = 2 * TABLE_SIZE;
    localparam int            AW        = $clog2(DEPTH);
    localparam int            EW        = $clog2(2*KICK_LIMIT + 1);
    localparam logic [EW-1:0] EVICT_MAX = EW'(2*KICK_LIMIT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [KEY_W-1:0]      mem [DEPTH];
    logic [KEY_W-1:0]      rd_data_reg;

    logic [KEY_W-1:0]      key_reg;
    logic                  mode_reg;
    logic [KEY_W-1:0]      resid_reg;
    logic                  side_reg;
    logic [EW-1:0]         evict_cnt_reg;
    logic [AW-1:0]         slot_cur_reg;
    logic [AW-1:0]         clr_addr_reg;
    status_t               res_status_reg;
    logic [AW-1:0]         res_slot_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;

    logic                  hash_start;
    logic [KEY_W-1:0]      hash_key;
    logic                  hash_done;
    logic [AW-1:0]         slot_a;
    logic [AW-1:0]         slot_b;
    logic [AW-1:0]         side_slot;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [KEY_W-1:0]      wr_data;
    logic [AW-1:0]         res_slot_next;
    logic [31:0]           res_slot_wide;

    assign hash_start = cmd.accept | cmd.kick;
    assign hash_key   = cmd.accept ? req_key : resid_reg;

    chpt_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (hash_key),
        .done   (hash_done),
        .slot_a (slot_a),
        .slot_b (slot_b)
    );

    assign side_slot = side_reg ? slot_b : slot_a;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_SEL_A:    rd_addr = slot_a;
            RD_SEL_B:    rd_addr = slot_b;
            RD_SEL_SIDE: rd_addr = side_slot;
            default:     rd_addr = slot_a;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_SEL_CLR: wr_addr = clr_addr_reg;
            WR_SEL_A:   wr_addr = slot_a;
            WR_SEL_B:   wr_addr = slot_b;
            WR_SEL_CUR: wr_addr = slot_cur_reg;
            default:    wr_addr = clr_addr_reg;
        endcase
    end

    assign wr_data = (cmd.wr_sel == WR_SEL_CLR) ? EMPTY_KEY : key_reg;

    always_comb
    begin
        unique case (cmd.res_slot)
            RS_NONE: res_slot_next = '0;
            RS_A:    res_slot_next = slot_a;
            RS_B:    res_slot_next = slot_b;
            default: res_slot_next = '0;
        endcase
    end

    // key store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg      <= 1'b0;
            evict_cnt_reg <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                side_reg      <= 1'b0;
                evict_cnt_reg <= '0;
            end
            else if (cmd.kick)
            begin
                side_reg      <= ~side_reg;
                evict_cnt_reg <= evict_cnt_reg + EW'(1);
            end
            if (cmd.wr_en && (cmd.wr_sel == WR_SEL_CLR))
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_slot_wide = 32'(res_slot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg  <= req_key;
            mode_reg <= req_mode;
        end
        else if (cmd.kick)
        begin
            key_reg <= resid_reg;
        end
        if (cmd.cap_resid)
        begin
            resid_reg <= rd_data_reg;
        end
        if (cmd.cur_from_a)
        begin
            slot_cur_reg <= slot_a;
        end
        else if (cmd.rd_en && (cmd.rd_sel == RD_SEL_SIDE))
        begin
            slot_cur_reg <= side_slot;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= res_slot_next;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_wide[SLOT_OUT_W-1:0];
        end
    end

    assign sts.hash_done  = hash_done;
    assign sts.key_zero   = (key_reg == EMPTY_KEY);
    assign sts.mode_find  = (mode_reg == MODE_FIND);
    assign sts.rd_zero    = (rd_data_reg == EMPTY_KEY);
    assign sts.rd_hit     = (rd_data_reg == key_reg);
    assign sts.resid_zero = (resid_reg == EMPTY_KEY);
    assign sts.evict_last = (evict_cnt_reg == EVICT_MAX);
    assign sts.clear_last = (clr_addr_reg == LAST_ADDR);
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_slot   = out_slot_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("pending response word overwritten");

    a_kick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kick |-> (resid_reg != EMPTY_KEY))
        else $error("eviction of an empty slot");

    a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kick |-> (evict_cnt_reg < EVICT_MAX))
        else $error("eviction count past limit");
`endif

endmodule

@@ src/chpt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chpt_ctrl
// Sequencer for clearing, lookup, insertion and the eviction chain.
// ----------------------------------------------------------------------------
module chpt_ctrl import chpt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  chpt_sts_t sts,
    output chpt_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_CLEAR      = 11'b000_0000_0001,
        S_IDLE       = 11'b000_0000_0010,
        S_HASH_WAIT  = 11'b000_0000_0100,
        S_RD_A       = 11'b000_0000_1000,
        S_CHK_A      = 11'b000_0001_0000,
        S_CHK_B      = 11'b000_0010_0000,
        S_KICK       = 11'b000_0100_0000,
        S_KHASH_WAIT = 11'b000_1000_0000,
        S_K_RD       = 11'b001_0000_0000,
        S_K_CHK      = 11'b010_0000_0000,
        S_RESULT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SEL_CLR;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_HASH_WAIT;
                end
            end
            S_HASH_WAIT:
            begin
                if (sts.hash_done)
                begin
                    if (sts.key_zero)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = sts.mode_find ? ST_ABSENT : ST_FAILED;
                        cmd.res_slot   = RS_NONE;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_RD_A;
                    end
                end
            end
            S_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_A;
                state_next = S_CHK_A;
            end
            S_CHK_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_B;
                if (sts.rd_hit)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_PRESENT;
                    cmd.res_slot   = RS_A;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.cap_resid = 1'b1;
                    state_next    = S_CHK_B;
                end
            end
            S_CHK_B:
            begin
                cmd.res_load = 1'b1;
                cmd.res_slot = RS_NONE;
                state_next   = S_RESULT;
                priority if (sts.rd_hit)
                begin
                    cmd.res_status = ST_PRESENT;
                    cmd.res_slot   = RS_B;
                end
                else if (sts.mode_find)
                begin
                    cmd.res_status = ST_ABSENT;
                end
                else if (sts.resid_zero)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = WR_SEL_A;
                    cmd.res_status = ST_INSERTED;
                end
                else if (sts.rd_zero)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = WR_SEL_B;
                    cmd.res_status = ST_INSERTED;
                end
                else
                begin
                    cmd.res_load   = 1'b0;
                    cmd.cur_from_a = 1'b1;
                    state_next     = S_KICK;
                end
            end
            S_KICK:
            begin
                cmd.kick   = 1'b1;
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SEL_CUR;
                state_next = S_KHASH_WAIT;
            end
            S_KHASH_WAIT:
            begin
                if (sts.hash_done)
                begin
                    state_next = S_K_RD;
                end
            end
            S_K_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_SIDE;
                state_next = S_K_CHK;
            end
            S_K_CHK:
            begin
                priority if (sts.rd_zero)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = WR_SEL_CUR;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_INSERTED;
                    cmd.res_slot   = RS_NONE;
                    state_next     = S_RESULT;
                end
                else if (sts.evict_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FAILED;
                    cmd.res_slot   = RS_NONE;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.cap_resid = 1'b1;
                    state_next    = S_KICK;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

`ifndef SYNTHESIS
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sts.hash_done |-> (state_reg == S_HASH_WAIT || state_reg == S_KHASH_WAIT))
        else $error("hash result arrived outside a wait state");
`endif

endmodule

@@ src/cuckoo_hash_code_point_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuckoo_hash_code_point_table_core
// Two-way cuckoo hash table of nonzero 32-bit keys with find and insert.
// ----------------------------------------------------------------------------
//
//   channel | role | word fields             | handshake
//   --------+------+-------------------------+------------------------------
//   req     | sink | mode (1), key (32)      | taken when valid && ready
//   rsp     | src  | status (2), slot (11)   | taken when valid && ready
//
// After reset a clearing pass writes all 2*TABLE_SIZE slots (2048 by default)
// empty, one slot a cycle; req.ready stays low until it ends. A find, or an
// insert that finds the key or an empty home slot, runs through the hash
// unit, up to three store reads and checks, the load of the response word
// and a return to idle. A key found in half one ends after its first check;
// a zero key skips the store. Each eviction adds a write, a rehash, a read
// and a check, and an insert makes at most 2*KICK_LIMIT evictions; the
// single store port and the four-stage hash set this sequence.
// A stalled rsp holds its word while the next request is taken and worked;
// the new result waits until the response register frees.
//
// Keys live in one memory of 2*TABLE_SIZE words: half one at h1(k), half two
// at TABLE_SIZE + h2(k). A word of zero marks an empty slot.
// ----------------------------------------------------------------------------
module cuckoo_hash_code_point_table_core import chpt_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KICK_LIMIT = DEF_KICK_LIMIT
) (
    input  logic       clk,
    input  logic       rst_n,
    chpt_req_if.sink   req,
    chpt_rsp_if.source rsp
);

    chpt_cmd_t cmd;
    chpt_sts_t sts;

    // sequencer: clearing pass, lookup, insert and the eviction chain
    chpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // store, hash unit and word registers
    chpt_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .KICK_LIMIT (KICK_LIMIT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_mode   (req.mode),
        .req_key    (req.key),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .rsp_status (rsp.status),
        .rsp_slot   (rsp.slot)
    );

endmodule

@@ dv/tb_cuckoo_hash_code_point_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cuckoo_hash_code_point_table_core
// Self-checking bench for the two-way cuckoo hash table core.
// A short table of directed words, then random finds and inserts, is driven
// on the request channel. A shadow copy of the table predicts each response
// word. Responses are compared in order with the predictions. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_cuckoo_hash_code_point_table_core import chpt_pkg::*;;

    localparam int TS             = DEF_TABLE_SIZE;
    localparam int KL             = DEF_KICK_LIMIT;
    localparam int SLOTS          = 2 * TS;
    localparam int RANDOM_WORDS   = 1700;
    localparam int CLASS_POOL     = 48;
    localparam int HISTORY_DEPTH  = 256;
    // The longest gap between accepted words is the clearing pass after
    // reset or a failed insert, plus both stalls.
    localparam int WATCHDOG_LIMIT = 4 * (SLOTS + 9 + 14 * KL + 16);
    // A settling wait at the end, to catch stray words.
    localparam int SETTLE_CYCLES  = 2 * (9 + 14 * KL);

    // One predicted response word.
    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
    } outcome_t;

    // One row of the directed table. Where typed is set, the row carries
    // its own expected word; else the shadow table decides.
    typedef struct {
        logic                  mode;
        logic [KEY_W-1:0]      key;
        bit                    typed;
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
    } directed_row_t;

    logic clk;
    logic rst_n;

    chpt_req_if req_ch ();
    chpt_rsp_if rsp_ch ();

    cuckoo_hash_code_point_table_core #(
        .TABLE_SIZE (TS),
        .KICK_LIMIT (KL)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the key store: half one in [0, TS), half two in [TS, 2*TS).
    logic [KEY_W-1:0] model_keys [SLOTS];
    outcome_t         pending_outcomes [$];
    logic [KEY_W-1:0] inserted_history [$];
    logic [9:0]       hot_classes [CLASS_POOL];

    int  mismatches;
    int  idle_cycles;
    int  words_sent;
    int  status_seen [4];
    bit  calm;

    // Keys 0x400, 0x800 and 0xC00 share both home slots, so the third one
    // runs the kick chain to its limit and fails.
    directed_row_t directed_rows [22] = '{
        '{MODE_FIND,   32'h0000_0001, 1'b1, ST_ABSENT,   '0},
        '{MODE_FIND,   32'h0000_0000, 1'b1, ST_ABSENT,   '0},
        '{MODE_INSERT, 32'h0000_0000, 1'b1, ST_FAILED,   '0},
        '{MODE_FIND,   32'hFFFF_FFFF, 1'b1, ST_ABSENT,   '0},
        '{MODE_INSERT, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, '0},
        '{MODE_INSERT, 32'hFFFF_FFFF, 1'b0, ST_PRESENT,  '0},
        '{MODE_FIND,   32'hFFFF_FFFF, 1'b0, ST_PRESENT,  '0},
        '{MODE_INSERT, 32'h0000_0001, 1'b1, ST_INSERTED, '0},
        '{MODE_FIND,   32'h0000_0001, 1'b0, ST_PRESENT,  '0},
        '{MODE_INSERT, 32'h0000_0400, 1'b1, ST_INSERTED, '0},
        '{MODE_INSERT, 32'h0000_0800, 1'b1, ST_INSERTED, '0},
        '{MODE_INSERT, 32'h0000_0C00, 1'b1, ST_FAILED,   '0},
        '{MODE_FIND,   32'h0000_0400, 1'b0, ST_PRESENT,  '0},
        '{MODE_FIND,   32'h0000_0800, 1'b0, ST_PRESENT,  '0},
        '{MODE_FIND,   32'h0000_0C00, 1'b0, ST_PRESENT,  '0},
        '{MODE_INSERT, 32'h0000_0400, 1'b0, ST_PRESENT,  '0},
        '{MODE_INSERT, 32'h8000_0000, 1'b0, ST_FAILED,   '0},
        '{MODE_INSERT, 32'h7FFF_FFFF, 1'b1, ST_INSERTED, '0},
        '{MODE_FIND,   32'h7FFF_FFFF, 1'b0, ST_PRESENT,  '0},
        '{MODE_INSERT, 32'hAAAA_AAAA, 1'b0, ST_INSERTED, '0},
        '{MODE_FIND,   32'h5555_5555, 1'b1, ST_ABSENT,   '0},
        '{MODE_INSERT, 32'h5555_5555, 1'b0, ST_INSERTED, '0}
    };

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------
    function automatic int unsigned home_one(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] p;
        p = k * MUL_ONE;
        return p % TS;
    endfunction

    function automatic int unsigned home_two(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] p;
        p = k * MUL_TWO;
        return p % TS + TS;
    endfunction

    // Fill an empty home slot, else kick residents back and forth between
    // the halves. On failure the last displaced key is simply dropped.
    function automatic bit place_key(logic [KEY_W-1:0] k);
        int unsigned      a;
        int unsigned      b;
        logic [KEY_W-1:0] moved;
        a = home_one(k);
        b = home_two(k);
        if (model_keys[a] == EMPTY_KEY)
        begin
            model_keys[a] = k;
            return 1'b1;
        end
        if (model_keys[b] == EMPTY_KEY)
        begin
            model_keys[b] = k;
            return 1'b1;
        end
        for (int round = 0; round < KL; round++)
        begin
            moved         = model_keys[a];
            model_keys[a] = k;
            k             = moved;
            b             = home_two(k);
            if (model_keys[b] == EMPTY_KEY)
            begin
                model_keys[b] = k;
                return 1'b1;
            end
            moved         = model_keys[b];
            model_keys[b] = k;
            k             = moved;
            a             = home_one(k);
            if (model_keys[a] == EMPTY_KEY)
            begin
                model_keys[a] = k;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the response word for one request and update the shadow.
    function automatic outcome_t hash_outcome(logic mode, logic [KEY_W-1:0] k);
        outcome_t    o;
        int unsigned a;
        int unsigned b;
        o.slot = '0;
        a      = home_one(k);
        b      = home_two(k);
        if (k == EMPTY_KEY)
            o.status = (mode == MODE_FIND) ? ST_ABSENT : ST_FAILED;
        else if (model_keys[a] == k)
        begin
            o.status = ST_PRESENT;
            o.slot   = SLOT_OUT_W'(a);
        end
        else if (model_keys[b] == k)
        begin
            o.status = ST_PRESENT;
            o.slot   = SLOT_OUT_W'(b);
        end
        else if (mode == MODE_FIND)
            o.status = ST_ABSENT;
        else
            o.status = place_key(k) ? ST_INSERTED : ST_FAILED;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------
    // Draw a wait for one word; hold at zero through calm stretches.
    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Drive one request word and hold it until taken. Ready is sampled at
    // the falling edge, where nothing driven at the rising edge is moving;
    // the word is taken at the rising edge that follows.
    task automatic send_word(input logic mode, input logic [KEY_W-1:0] k,
                             input bit typed, input outcome_t typed_out);
        int       gap;
        outcome_t predicted;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.key   <= k;
        forever
        begin
            @(negedge clk);
            if (req_ch.ready)
                break;
        end
        @(posedge clk);
        // Always step the shadow so its state follows the block.
        predicted = hash_outcome(mode, k);
        pending_outcomes.push_back(typed ? typed_out : predicted);
        words_sent++;
        if (mode == MODE_INSERT && k != EMPTY_KEY)
        begin
            inserted_history.push_back(k);
            if (inserted_history.size() > HISTORY_DEPTH)
                void'(inserted_history.pop_front());
        end
    endtask

    // Hold off until every predicted word has come back.
    task automatic drain_outcomes();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        outcome_t         typed_out;
        int               pick;
        logic             mode;
        logic [KEY_W-1:0] k;

        foreach (model_keys[i])
            model_keys[i] = EMPTY_KEY;
        foreach (hot_classes[i])
            hot_classes[i] = 10'($urandom);
        mismatches   = 0;
        words_sent   = 0;
        calm         = 1'b0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= MODE_INSERT;
        req_ch.key   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: empty table, zero key, extremes, kick failure.
        foreach (directed_rows[i])
        begin
            typed_out.status = directed_rows[i].status;
            typed_out.slot   = directed_rows[i].slot;
            send_word(directed_rows[i].mode, directed_rows[i].key,
                      directed_rows[i].typed, typed_out);
        end
        req_ch.valid <= 1'b0;
        drain_outcomes();

        typed_out = '0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // Hold the sender back once mid-run until the block is quiet.
            if (n == RANDOM_WORDS / 2)
            begin
                req_ch.valid <= 1'b0;
                drain_outcomes();
            end
            // A stretch with no idling on either side.
            calm = (n >= 400 && n < 600);
            pick = int'($urandom_range(0, 99));
            mode = 1'($urandom_range(0, 1));
            // Keys sharing low ten bits share both home slots, so a small
            // pool of classes drives fills, kicks and failed inserts.
            k    = ($urandom & ~32'h3FF) | hot_classes[$urandom_range(0, CLASS_POOL - 1)];
            if (pick < 5)
                k = EMPTY_KEY;
            else if (pick < 40)
                mode = MODE_INSERT;
            else if (pick < 80 && inserted_history.size() != 0)
            begin
                mode = (pick < 70) ? MODE_FIND : MODE_INSERT;
                k    = inserted_history[$urandom_range(0, inserted_history.size() - 1)];
            end
            else if (pick < 90)
                mode = MODE_FIND;
            else
                k = $urandom;
            send_word(mode, k, 1'b0, typed_out);
        end
        req_ch.valid <= 1'b0;
        calm = 1'b0;

        drain_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d request words: %0d inserted, %0d present, %0d absent, %0d failed",
                 words_sent, status_seen[ST_INSERTED], status_seen[ST_PRESENT],
                 status_seen[ST_ABSENT], status_seen[ST_FAILED]);
        $display("Covered zero keys, full-range keys and shared-slot kick chains");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------
    // Stall ready for a drawn number of cycles before each word.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(negedge clk);
            while (!rsp_ch.valid);
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Checker and watchdog
    // ------------------------------------------------------------------
    // Sample at the falling edge: both channels are stable there, and a
    // word seen with valid and ready high is taken at the next rising edge.
    initial
        idle_cycles = 0;

    always @(negedge clk)
    begin
        outcome_t exp_word;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_ch.status inside {[0:3]})
                status_seen[rsp_ch.status]++;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response word status %0d slot %0d",
                         $realtime, rsp_ch.status, rsp_ch.slot);
            end
            else
            begin
                exp_word = pending_outcomes.pop_front();
                if (rsp_ch.status !== exp_word.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %s (%0d) actual %0d", $realtime,
                             exp_word.status.name(), exp_word.status, rsp_ch.status);
                end
                if (rsp_ch.slot !== exp_word.slot)
                begin
                    mismatches++;
                    $display("%0t: slot expected %0d actual %0d",
                             $realtime, exp_word.slot, rsp_ch.slot);
                end
            end
        end

        // Advance the idle count on cycles with no word taken on either side.
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word taken for %0d cycles, %0d responses outstanding",
                     $realtime, idle_cycles, pending_outcomes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

@@ cuckoo_hash_code_point_table_core.f @@
src/chpt_pkg.sv
src/chpt_req_if.sv
src/chpt_rsp_if.sv
src/chpt_hash.sv
src/chpt_datapath.sv
src/chpt_ctrl.sv
src/cuckoo_hash_code_point_table_core.sv
dv/tb_cuckoo_hash_code_point_table_core.sv
